### hw/rtl/prc_pkg.sv
package prc_pkg;

  typedef struct packed {
    logic [3:0]  exec_mode;
    logic [3:0]  op_kind;
    logic [10:0] type_codes;
    logic [8:0]  flags;
    logic [3:0]  topo_levels;
    logic [15:0] net_instances;
    logic [15:0] rank_count;
    logic [63:0] data_size;
  } query_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  slot;
    logic [1:0]  wsel;
    logic [63:0] word;
  } load_t;

  typedef struct packed {
    logic       active;
    logic       found;
    logic [7:0] alg;
    logic [4:0] slot;
  } carry_t;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [1:0] TOPO_ANY   = 2'd0;
  localparam logic [1:0] TOPO_MULTI = 2'd1;

  function automatic logic [3:0] norm4(input logic [3:0] c, input logic [3:0] unk);
    norm4 = (c >= unk) ? unk : c;
  endfunction

  function automatic logic rule_match(input logic [3:0][63:0] w, input query_t q);
    logic [63:0] c;
    logic [3:0]  dt;
    logic        ok;
    c  = w[0];
    dt = norm4(q.type_codes[7:4], 4'd8);
    ok = 1'b1;
    if (c[0] && norm4(c[4:1], 4'd8) != norm4(q.exec_mode, 4'd8)) ok = 1'b0;
    if (c[5] && norm4(c[9:6], 4'd14) != norm4(q.op_kind, 4'd14)) ok = 1'b0;
    if (c[11:10] == TOPO_MULTI && q.topo_levels <= 4'd1) ok = 1'b0;
    if (c[11] && q.topo_levels != c[15:12]) ok = 1'b0;
    if (c[16] && c[18:17] != q.type_codes[1:0]) ok = 1'b0;
    if (c[19] && c[21:20] != q.type_codes[3:2]) ok = 1'b0;
    if (((c[53:45] ^ q.flags) & c[44:36]) != 9'd0) ok = 1'b0;
    if (c[54] && w[1][15:0] != q.net_instances) ok = 1'b0;
    if (c[55] && q.rank_count < w[1][31:16]) ok = 1'b0;
    if (c[56] && q.rank_count > w[1][47:32]) ok = 1'b0;
    if (c[57] && q.data_size < w[2]) ok = 1'b0;
    if (c[58] && q.data_size >= w[3]) ok = 1'b0;
    if (c[26] && !c[27 + dt]) ok = 1'b0;
    if (c[22] && norm4({1'b0, c[25:23]}, 4'd4) != norm4({1'b0, q.type_codes[10:8]}, 4'd4))
      ok = 1'b0;
    rule_match = ok;
  endfunction

endpackage

### hw/rtl/priority_rule_classifier.sv
// A load's result is registered in the cycle after acceptance. A query passes
// through start_r, then one registered rule cell per slot in chain order,
// then the output register. One item at a time: a new item is taken only
// once the previous result has been taken.
// Reset clears control state and rules_in_use; rule contents are undefined.
module priority_rule_classifier #(
  parameter int RULE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [4:0]  in_rule_slot,
  input  logic [1:0]  in_word_select,
  input  logic [63:0] in_rule_word,
  input  logic [3:0]  in_exec_mode,
  input  logic [3:0]  in_op_kind,
  input  logic [10:0] in_type_codes,
  input  logic [8:0]  in_flags,
  input  logic [3:0]  in_topo_levels,
  input  logic [15:0] in_net_instances,
  input  logic [15:0] in_rank_count,
  input  logic [63:0] in_data_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_algorithm_id,
  output logic [4:0]  out_hit_slot
);
  import prc_pkg::*;

  logic [5:0]  rules_in_use_r;
  logic        busy_r;
  logic        start_r;
  logic        out_valid_r;
  logic        found_r;
  logic [7:0]  alg_r;
  logic [4:0]  slot_r;
  query_t      qry_r;
  load_t       load;
  logic        in_fire;
  carry_t      chain [RULE_SLOTS+1];
  logic [RULE_SLOTS-1:0] act_vec;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !busy_r && !out_valid_r;

  assign load.we   = in_fire && (in_command == CMD_LOAD);
  assign load.slot = in_rule_slot;
  assign load.wsel = in_word_select;
  assign load.word = in_rule_word;

  assign chain[0].active = start_r;
  assign chain[0].found  = 1'b0;
  assign chain[0].alg    = 8'd0;
  assign chain[0].slot   = 5'd0;

  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
    prc_cell #(.IDX(i)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .load         (load),
      .qry          (qry_r),
      .rules_in_use (rules_in_use_r),
      .carry_in     (chain[i]),
      .carry_out    (chain[i+1])
    );
    assign act_vec[i] = chain[i+1].active;
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_command == CMD_CLASSIFY) begin
      qry_r.exec_mode     <= in_exec_mode;
      qry_r.op_kind       <= in_op_kind;
      qry_r.type_codes    <= in_type_codes;
      qry_r.flags         <= in_flags;
      qry_r.topo_levels   <= in_topo_levels;
      qry_r.net_instances <= in_net_instances;
      qry_r.rank_count    <= in_rank_count;
      qry_r.data_size     <= in_data_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rules_in_use_r <= 6'd0;
      busy_r         <= 1'b0;
      start_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        rules_in_use_r <= cfg_wdata;
      end
      start_r <= in_fire && (in_command == CMD_CLASSIFY);
      if (in_fire && in_command == CMD_CLASSIFY) begin
        busy_r <= 1'b1;
      end else if (chain[RULE_SLOTS].active) begin
        busy_r <= 1'b0;
      end
      if (load.we || chain[RULE_SLOTS].active) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.we) begin
      found_r <= 1'b0;
      alg_r   <= 8'd0;
      slot_r  <= 5'd0;
    end else if (chain[RULE_SLOTS].active) begin
      found_r <= chain[RULE_SLOTS].found;
      alg_r   <= chain[RULE_SLOTS].found ? chain[RULE_SLOTS].alg : 8'd0;
      slot_r  <= chain[RULE_SLOTS].found ? chain[RULE_SLOTS].slot : 5'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_algorithm_id = alg_r;
  assign out_hit_slot     = slot_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(act_vec))
    else $error("More than one query is traveling the rule chain.");
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !in_ready)
    else $error("Input accepted while a query is in flight.");
  a_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (act_vec == '0 && !start_r))
    else $error("Rule chain active while no query is in flight.");

endmodule

### hw/rtl/prc_cell.sv
module prc_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  prc_pkg::load_t  load,
  input  prc_pkg::query_t qry,
  input  logic [5:0]      rules_in_use,
  input  prc_pkg::carry_t carry_in,
  output prc_pkg::carry_t carry_out
);
  import prc_pkg::*;

  localparam logic [8:0] IDX_W = 9'(IDX);

  logic [3:0][63:0] rule_r;
  carry_t           carry_r;
  carry_t           carry_nxt;
  logic             take;

  always_ff @(posedge clk) begin
    if (load.we && {4'd0, load.slot} == IDX_W) begin
      rule_r[load.wsel] <= load.word;
    end
  end

  assign take = carry_in.active && !carry_in.found && (IDX_W < {3'd0, rules_in_use})
                && rule_match(rule_r, qry) && rule_r[0][59];

  always_comb begin
    carry_nxt = carry_in;
    if (take) begin
      carry_nxt.found = 1'b1;
      carry_nxt.alg   = rule_r[1][55:48];
      carry_nxt.slot  = IDX_W[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.active <= 1'b0;
    end else begin
      carry_r.active <= carry_nxt.active;
    end
    carry_r.found <= carry_nxt.found;
    carry_r.alg   <= carry_nxt.alg;
    carry_r.slot  <= carry_nxt.slot;
  end

  assign carry_out = carry_r;

endmodule

### bench/tb_priority_rule_classifier.sv
module tb_priority_rule_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import prc_pkg::*;

  typedef struct {
    logic        cmd;
    logic [4:0]  slot;
    logic [1:0]  wsel;
    logic [63:0] word;
    query_t      q;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] alg;
    logic [4:0] slot;
  } verdict_t;

  class rule_scoreboard;
    logic [63:0] rule_mem[32][4];
    int unsigned scan_count;
    verdict_t verdict_q[$];
    int errors;

    function logic [3:0] clamp_code(logic [3:0] c, logic [3:0] unk);
      return (c >= unk) ? unk : c;
    endfunction

    function bit rule_hits(int s, query_t q);
      logic [63:0] c;
      logic [63:0] w1;
      logic [3:0] dt;
      c = rule_mem[s][0];
      w1 = rule_mem[s][1];
      dt = clamp_code(q.type_codes[7:4], 4'd8);
      if (c[0] && clamp_code(c[4:1], 4'd8) != clamp_code(q.exec_mode, 4'd8)) return 0;
      if (c[5] && clamp_code(c[9:6], 4'd14) != clamp_code(q.op_kind, 4'd14)) return 0;
      if (c[11:10] == TOPO_MULTI && q.topo_levels <= 4'd1) return 0;
      if (c[11] && q.topo_levels != c[15:12]) return 0;
      if (c[16] && c[18:17] != q.type_codes[1:0]) return 0;
      if (c[19] && c[21:20] != q.type_codes[3:2]) return 0;
      if (((c[53:45] ^ q.flags) & c[44:36]) != 9'd0) return 0;
      if (c[54] && w1[15:0] != q.net_instances) return 0;
      if (c[55] && q.rank_count < w1[31:16]) return 0;
      if (c[56] && q.rank_count > w1[47:32]) return 0;
      if (c[57] && q.data_size < rule_mem[s][2]) return 0;
      if (c[58] && q.data_size >= rule_mem[s][3]) return 0;
      if (c[26] && !c[27 + dt]) return 0;
      if (c[22] && clamp_code({1'b0, c[25:23]}, 4'd4) !=
          clamp_code({1'b0, q.type_codes[10:8]}, 4'd4)) return 0;
      return 1;
    endfunction

    function void note_item(item_t it);
      verdict_t v;
      int n;
      v = '0;
      if (it.cmd == CMD_LOAD) begin
        rule_mem[it.slot][it.wsel] = it.word;
      end else begin
        n = (scan_count > 32) ? 32 : int'(scan_count);
        for (int s = 0; s < n; s++) begin
          if (rule_mem[s][0][59] && rule_hits(s, it.q)) begin
            v.found = 1'b1;
            v.alg = rule_mem[s][1][55:48];
            v.slot = 5'(s);
            break;
          end
        end
      end
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    function void check_result(logic found, logic [7:0] alg, logic [4:0] slot);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (found !== v.found) begin
        $error("found: expected %0d actual %0d", v.found, found);
        errors++;
      end
      if (alg !== v.alg) begin
        $error("algorithm_id: expected %0d actual %0d", v.alg, alg);
        errors++;
      end
      if (slot !== v.slot) begin
        $error("hit_slot: expected %0d actual %0d", v.slot, slot);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [4:0] in_rule_slot = '0;
  logic [1:0] in_word_select = '0;
  logic [63:0] in_rule_word = '0;
  logic [3:0] in_exec_mode = '0;
  logic [3:0] in_op_kind = '0;
  logic [10:0] in_type_codes = '0;
  logic [8:0] in_flags = '0;
  logic [3:0] in_topo_levels = '0;
  logic [15:0] in_net_instances = '0;
  logic [15:0] in_rank_count = '0;
  logic [63:0] in_data_size = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [7:0] out_algorithm_id;
  logic [4:0] out_hit_slot;

  rule_scoreboard sb = new();
  bit calm = 0;
  bit held_once = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  priority_rule_classifier dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_rule_slot(in_rule_slot), .in_word_select(in_word_select),
    .in_rule_word(in_rule_word), .in_exec_mode(in_exec_mode), .in_op_kind(in_op_kind),
    .in_type_codes(in_type_codes), .in_flags(in_flags), .in_topo_levels(in_topo_levels),
    .in_net_instances(in_net_instances), .in_rank_count(in_rank_count),
    .in_data_size(in_data_size), .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_algorithm_id(out_algorithm_id), .out_hit_slot(out_hit_slot)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      sb.check_result(out_found, out_algorithm_id, out_hit_slot);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 4000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!held_once && results_seen >= 400) begin
        held_once = 1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rule_word_for(int wsel);
    logic [63:0] w;
    w = rand64();
    if (wsel == 0) begin
      foreach (w[i]) begin
        if (i == 0 || i == 5 || i == 16 || i == 19 || i == 22 || i == 26 ||
            (i >= 54 && i <= 58))
          w[i] = ($urandom_range(3) == 0);
      end
      w[44:36] = w[44:36] & 9'($urandom) & 9'($urandom);
      w[59] = ($urandom_range(4) != 0);
    end
    return w;
  endfunction

  task automatic send_item(item_t it);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_command <= it.cmd;
    in_rule_slot <= it.slot;
    in_word_select <= it.wsel;
    in_rule_word <= it.word;
    in_exec_mode <= it.q.exec_mode;
    in_op_kind <= it.q.op_kind;
    in_type_codes <= it.q.type_codes;
    in_flags <= it.q.flags;
    in_topo_levels <= it.q.topo_levels;
    in_net_instances <= it.q.net_instances;
    in_rank_count <= it.q.rank_count;
    in_data_size <= it.q.data_size;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic load_word(int slot, int wsel, logic [63:0] word);
    item_t it;
    it = '{default: '0};
    it.cmd = CMD_LOAD;
    it.slot = 5'(slot);
    it.wsel = 2'(wsel);
    it.word = word;
    send_item(it);
  endtask

  task automatic classify(logic [3:0] em, logic [3:0] op, logic [10:0] tc, logic [8:0] fl,
                          logic [3:0] tp, logic [15:0] net, logic [15:0] rank,
                          logic [63:0] size);
    item_t it;
    it = '{default: '0};
    it.cmd = CMD_CLASSIFY;
    it.slot = 5'($urandom);
    it.wsel = 2'($urandom);
    it.word = rand64();
    it.q = '{em, op, tc, fl, tp, net, rank, size};
    send_item(it);
  endtask

  task automatic set_scan(int unsigned n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 6'(n);
    @(posedge clk);
    sb.scan_count = n;
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        int w;
        w = $urandom_range(3);
        load_word($urandom_range(31), w, rule_word_for(w));
      end else begin
        classify(4'($urandom), 4'($urandom), 11'($urandom), 9'($urandom), 4'($urandom),
                 16'($urandom_range(1) ? $urandom : $urandom_range(3)), 16'($urandom),
                 ($urandom_range(1) ? rand64() : 64'($urandom_range(4096))));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_scan(0);
    for (int s = 0; s < 32; s++)
      for (int w = 0; w < 4; w++) load_word(s, w, rule_word_for(w));
    classify(4'd0, 4'd0, 11'd0, 9'd0, 4'd0, 16'd0, 16'd0, 64'd0);
    set_scan(32);
    load_word(0, 0, 64'd0);
    load_word(1, 0, 64'h0800_0000_0000_0000);
    load_word(1, 1, 64'h00AB_0000_0000_0000);
    classify(4'd15, 4'd15, 11'h7FF, 9'h1FF, 4'd15, 16'hFFFF, 16'hFFFF, '1);
    classify(4'd0, 4'd0, 11'd0, 9'd0, 4'd0, 16'd0, 16'd0, 64'd0);
    load_word(1, 0, rule_word_for(0));
    load_word(31, 0, 64'h0800_0000_0000_0000);
    load_word(31, 1, 64'h00FF_0000_0000_0000);
    classify(4'd8, 4'd14, 11'h7F0, 9'h155, 4'd1, 16'h0001, 16'h8000, 64'h8000_0000_0000_0000);
    classify(4'd7, 4'd13, 11'h38F, 9'h0AA, 4'd2, 16'h7FFF, 16'd1, 64'd1);
    set_scan(1);
    random_phase(150);
    set_scan(63);
    random_phase(200);
    set_scan(33);
    random_phase(150);
    set_scan(32);
    calm = 1;
    random_phase(200);
    calm = 0;
    random_phase(150);
    set_scan($urandom_range(2, 31));
    random_phase(150);
    set_scan(0);
    random_phase(30);
    set_scan(32);
    random_phase(50);
    in_valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/prc_pkg.sv
hw/rtl/prc_cell.sv
hw/rtl/priority_rule_classifier.sv
bench/tb_priority_rule_classifier.sv
